// File: rtl/ckre_pkg.sv
package ckre_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEY_COLOR     = 3'd0,
      CSR_DELTA_X       = 3'd1,
      CSR_DELTA_Y       = 3'd2,
      CSR_SOURCE_WIDTH  = 3'd3,
      CSR_SOURCE_HEIGHT = 3'd4,
      CSR_DEST_WIDTH    = 3'd5,
      CSR_DEST_HEIGHT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] key_color;
      logic [13:0] delta_x;
      logic [13:0] delta_y;
      logic [12:0] source_width;
      logic [12:0] source_height;
      logic [12:0] dest_width;
      logic [12:0] dest_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [13:0] src_col;
      logic [13:0] src_row;
      logic        row_end;
   } item_type;

   typedef struct packed {
      logic [11:0] run_row;
      logic [11:0] run_left;
      logic [12:0] run_right;
   } run_type;

   typedef struct packed {
      logic        emit;
      logic        open_next;
      logic [11:0] start_next;
      run_type     run;
   } cls_type;

endpackage

// File: rtl/ckre_if.sv
interface ckre_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel;
   logic [13:0] src_col;
   logic [13:0] src_row;
   logic        row_end;

   modport source (output valid, pixel, src_col, src_row, row_end, input ready);
   modport sink   (input valid, pixel, src_col, src_row, row_end, output ready);
endinterface

interface ckre_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] run_row;
   logic [11:0] run_left;
   logic [12:0] run_right;

   modport source (output valid, run_row, run_left, run_right, input ready);
   modport sink   (input valid, run_row, run_left, run_right, output ready);
endinterface

interface ckre_csr_if;
   import ckre_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ckre_csr.sv
module ckre_csr #(
   parameter int MAX_DIM = 4096
) (
   input  logic              clock,
   input  logic              reset,
   ckre_csr_if.sink          csr_chan,
   output ckre_pkg::cfg_type cfg
);
   import ckre_pkg::*;

   localparam logic [13:0] MaxDim = 14'(MAX_DIM);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   function automatic logic [12:0] cap_dim(input logic [12:0] v);
      logic [12:0] r;
      r = ({1'b0, v} > MaxDim) ? MaxDim[12:0] : v;
      return r;
   endfunction

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_KEY_COLOR:     cfg_in.key_color     = csr_chan.data;
            CSR_DELTA_X:       cfg_in.delta_x       = csr_chan.data[13:0];
            CSR_DELTA_Y:       cfg_in.delta_y       = csr_chan.data[13:0];
            CSR_SOURCE_WIDTH:  cfg_in.source_width  = cap_dim(csr_chan.data[12:0]);
            CSR_SOURCE_HEIGHT: cfg_in.source_height = cap_dim(csr_chan.data[12:0]);
            CSR_DEST_WIDTH:    cfg_in.dest_width    = cap_dim(csr_chan.data[12:0]);
            CSR_DEST_HEIGHT:   cfg_in.dest_height   = cap_dim(csr_chan.data[12:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_color     <= '0;
         cfg_ff.delta_x       <= '0;
         cfg_ff.delta_y       <= '0;
         cfg_ff.source_width  <= 13'd1;
         cfg_ff.source_height <= 13'd1;
         cfg_ff.dest_width    <= 13'd1;
         cfg_ff.dest_height   <= 13'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/ckre_classify.sv
module ckre_classify (
   input  ckre_pkg::item_type item,
   input  ckre_pkg::cfg_type  cfg,
   input  logic               run_open,
   input  logic [11:0]        run_start,
   output ckre_pkg::cls_type  cls
);
   import ckre_pkg::*;

   logic [14:0] dcol;
   logic [14:0] drow;
   logic [15:0] dcol_inc;
   logic        row_ok;
   logic        opaque;
   logic        close_run;
   logic        open_after;
   logic        flush;

   function automatic logic [12:0] clamp_right(input logic [15:0] r, input logic [12:0] dw);
      logic [12:0] c;
      if (r[15]) begin
         c = '0;
      end else if (r[14:0] > {2'b00, dw}) begin
         c = dw;
      end else begin
         c = r[12:0];
      end
      return c;
   endfunction

   assign dcol     = {item.src_col[13], item.src_col} + {cfg.delta_x[13], cfg.delta_x};
   assign drow     = {item.src_row[13], item.src_row} + {cfg.delta_y[13], cfg.delta_y};
   assign dcol_inc = {dcol[14], dcol} + 16'd1;

   assign row_ok = !item.src_row[13] && (item.src_row[12:0] < cfg.source_height) &&
                   !drow[14] && (drow[13:0] < {1'b0, cfg.dest_height});

   assign opaque = !item.src_col[13] && (item.src_col[12:0] < cfg.source_width) &&
                   !dcol[14] && (dcol[13:0] < {1'b0, cfg.dest_width}) &&
                   (item.pixel != cfg.key_color);

   assign close_run  = row_ok && !opaque && run_open;
   assign open_after = row_ok && opaque;
   assign flush      = open_after && item.row_end;

   always_comb begin
      cls.emit          = close_run || flush;
      cls.open_next     = open_after && !item.row_end;
      cls.start_next    = (opaque && !run_open) ? dcol[11:0] : run_start;
      cls.run.run_row   = drow[11:0];
      cls.run.run_left  = cls.start_next;
      cls.run.run_right = flush ? clamp_right(dcol_inc, cfg.dest_width)
                                : clamp_right({dcol[14], dcol}, cfg.dest_width);
   end

endmodule

// File: rtl/color_key_opaque_run_extractor_unit.sv
// Colour-key opaque run extractor.
// req_chan takes one source pixel per beat in raster order with its source
// column, source row and an end-of-row mark. rsp_chan gives one beat per
// finished opaque run: destination row, first column and exclusive right end.
// csr_chan writes the key colour, the blit offsets and the surface sizes by
// register index; it is always ready. The user must write it only while no
// pixel is in flight; the block itself does not enforce this.
// Throughput: one pixel per cycle while rsp_chan is not stalled. A pixel sits
// in the input register, its run decision is made there, and the run lands in
// the output register, from which rsp_chan offers it.
// When rsp_chan stalls, the output register holds the run; one more pixel is
// taken into the input register and req_chan.ready then drops until the
// output register drains.
// Reset clears the open run, empties both registers and loads the register
// defaults: key colour zero, offsets zero, all surface sizes one.
module color_key_opaque_run_extractor_unit #(
   parameter int MAX_DIM = 4096
) (
   input logic      clock,
   input logic      reset,
   ckre_req_if.sink req_chan,
   ckre_rsp_if.source rsp_chan,
   ckre_csr_if.sink csr_chan
);
   import ckre_pkg::*;

   cfg_type     cfg;
   cls_type     cls;

   logic        item_valid_ff;
   logic        item_valid_in;
   item_type    item_ff;
   item_type    item_in;
   logic        run_open_ff;
   logic        run_open_in;
   logic [11:0] run_start_ff;
   logic [11:0] run_start_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   run_type     out_ff;
   run_type     out_in;

   logic        advance;
   logic        accept;

   ckre_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ckre_classify u_classify (
      .item      (item_ff),
      .cfg       (cfg),
      .run_open  (run_open_ff),
      .run_start (run_start_ff),
      .cls       (cls)
   );

   assign advance        = item_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.run_row   = out_ff.run_row;
   assign rsp_chan.run_left  = out_ff.run_left;
   assign rsp_chan.run_right = out_ff.run_right;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_in        = out_ff;
      if (advance) begin
         item_valid_in = 1'b0;
         run_open_in   = cls.open_next;
         run_start_in  = cls.start_next;
         if (cls.emit) begin
            out_valid_in = 1'b1;
            out_in       = cls.run;
         end
      end
      if (accept) begin
         item_valid_in   = 1'b1;
         item_in.pixel   = req_chan.pixel;
         item_in.src_col = req_chan.src_col;
         item_in.src_row = req_chan.src_row;
         item_in.row_end = req_chan.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         run_open_ff   <= 1'b0;
         run_start_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         run_open_ff   <= run_open_in;
         run_start_ff  <= run_start_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

endmodule

// File: rtl/ckre_checker.sv
module ckre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_run_row,
   input logic [11:0] rsp_run_left,
   input logic [12:0] rsp_run_right
);

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("run beat present straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_row) &&
         $stable(rsp_run_left) && $stable(rsp_run_right))
      else $error("stalled run beat changed or dropped");

   a_run_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("run beat without a pixel beat two cycles earlier");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pixel channel stalled while run channel drains");

endmodule

bind color_key_opaque_run_extractor_unit ckre_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_run_row   (rsp_chan.run_row),
   .rsp_run_left  (rsp_chan.run_left),
   .rsp_run_right (rsp_chan.run_right)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import ckre_pkg::*;

   localparam int DimLimit = 4096;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ckre_req_if req_chan ();
   ckre_rsp_if rsp_chan ();
   ckre_csr_if csr_chan ();

   color_key_opaque_run_extractor_unit #(
      .MAX_DIM(DimLimit)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   int blit_key = 0;
   int blit_dx = 0;
   int blit_dy = 0;
   int src_w = 1;
   int src_h = 1;
   int dst_w = 1;
   int dst_h = 1;
   bit run_is_open = 1'b0;
   logic [11:0] run_first_col = '0;

   run_type expected_runs[$];
   int error_count = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   logic rsp_hold = 1'b0;
   int rsp_stall_left = 0;

   function automatic int to_s14(logic [13:0] v);
      return int'($signed(v));
   endfunction

   function automatic int cap_size(logic [12:0] v);
      int d;
      d = int'(v);
      return d > DimLimit ? DimLimit : d;
   endfunction

   function automatic logic [12:0] clip_right(int r);
      if (r < 0) r = 0;
      if (r > dst_w) r = dst_w;
      return r[12:0];
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [15:0] value);
      case (idx)
         CSR_KEY_COLOR:     blit_key = int'(value);
         CSR_DELTA_X:       blit_dx = to_s14(value[13:0]);
         CSR_DELTA_Y:       blit_dy = to_s14(value[13:0]);
         CSR_SOURCE_WIDTH:  src_w = cap_size(value[12:0]);
         CSR_SOURCE_HEIGHT: src_h = cap_size(value[12:0]);
         CSR_DEST_WIDTH:    dst_w = cap_size(value[12:0]);
         CSR_DEST_HEIGHT:   dst_h = cap_size(value[12:0]);
         default: ;
      endcase
   endfunction

   function automatic void predict_pixel(item_type it);
      int scol, srow, dcol, drow;
      bit kept, lit, emit;
      run_type r;
      scol = to_s14(it.src_col);
      srow = to_s14(it.src_row);
      dcol = scol + blit_dx;
      drow = srow + blit_dy;
      emit = 1'b0;
      kept = srow >= 0 && srow < src_h && drow >= 0 && drow < dst_h;
      if (!kept) begin
         run_is_open = 1'b0;
         return;
      end
      lit = scol >= 0 && scol < src_w && dcol >= 0 && dcol < dst_w &&
            int'(it.pixel) != blit_key;
      if (lit && !run_is_open) begin
         run_is_open = 1'b1;
         run_first_col = dcol[11:0];
      end else if (!lit && run_is_open) begin
         r.run_row = drow[11:0];
         r.run_left = run_first_col;
         r.run_right = clip_right(dcol);
         run_is_open = 1'b0;
         emit = 1'b1;
      end
      if (it.row_end && run_is_open) begin
         r.run_row = drow[11:0];
         r.run_left = run_first_col;
         r.run_right = clip_right(dcol + 1);
         run_is_open = 1'b0;
         emit = 1'b1;
      end
      if (emit) expected_runs = {expected_runs, r};
   endfunction

   function automatic item_type make_pixel(int pix, int col, int row, bit last);
      item_type it;
      it.pixel = pix[15:0];
      it.src_col = col[13:0];
      it.src_row = row[13:0];
      it.row_end = last;
      return it;
   endfunction

   function automatic int pick_start(int extent);
      case ($urandom_range(0, 3))
         0: return -int'($urandom_range(0, 6));
         1: return extent - int'($urandom_range(1, 12));
         default: return $urandom_range(0, extent > 0 ? extent - 1 : 0);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_run;
      run_type want;
      if (expected_runs.size() == 0) begin
         report_mismatch($sformatf("unexpected run row %0d left %0d right %0d",
                                   rsp_chan.run_row, rsp_chan.run_left, rsp_chan.run_right));
         return;
      end
      want = expected_runs.pop_front();
      if (rsp_chan.run_row !== want.run_row)
         report_mismatch($sformatf("run_row got %0d expected %0d",
                                   rsp_chan.run_row, want.run_row));
      if (rsp_chan.run_left !== want.run_left)
         report_mismatch($sformatf("run_left got %0d expected %0d",
                                   rsp_chan.run_left, want.run_left));
      if (rsp_chan.run_right !== want.run_right)
         report_mismatch($sformatf("run_right got %0d expected %0d",
                                   rsp_chan.run_right, want.run_right));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_run();
            rsp_stall_left = rx_idle_on ? $urandom_range(0, 6) : 0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left = rsp_stall_left - 1;
         end
         rsp_chan.ready <= (rsp_stall_left == 0) && !rsp_hold;
      end
   end

   task automatic send_pixel(input item_type it);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= it.pixel;
      req_chan.src_col <= it.src_col;
      req_chan.src_row <= it.src_row;
      req_chan.row_end <= it.row_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_pixel(it);
   endtask

   task automatic release_pixels;
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain_runs;
      int waited;
      waited = 0;
      while (expected_runs.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_runs.size() != 0) begin
         report_mismatch($sformatf("%0d runs never arrived", expected_runs.size()));
         expected_runs.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      apply_csr(idx, value);
   endtask

   task automatic set_config(input int key, input int dx, input int dy, input int sw,
                             input int sh, input int dw, input int dh, input bit junk);
      logic [2:0] hi;
      write_reg(CSR_KEY_COLOR, key[15:0]);
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_DELTA_X, {hi[1:0], dx[13:0]});
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_DELTA_Y, {hi[1:0], dy[13:0]});
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_SOURCE_WIDTH, {hi, sw[12:0]});
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_SOURCE_HEIGHT, {hi, sh[12:0]});
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_DEST_WIDTH, {hi, dw[12:0]});
      hi = junk ? 3'($urandom_range(0, 7)) : 3'd0;
      write_reg(CSR_DEST_HEIGHT, {hi, dh[12:0]});
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_window(input int sx, input int sy, input int cols, input int rows,
                              input int key);
      bit lit;
      int pix;
      lit = 1'($urandom_range(0, 1));
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if ($urandom_range(0, 3) == 0) lit = !lit;
            pix = lit ? $urandom_range(0, 65535) : key;
            send_pixel(make_pixel(pix, sx + c, sy + r, c == cols - 1));
         end
      end
   endtask

   task automatic test_reset_defaults;
      send_pixel(make_pixel(16'hFFFF, 0, 0, 1'b1));
      send_pixel(make_pixel(16'h0000, 0, 0, 1'b1));
      release_pixels();
      drain_runs();
   endtask

   task automatic test_directed_edges;
      set_config(16'h1234, 2, 1, 8, 4, 8, 4, 1'b0);
      // run closed by key colour, then by the destination's right edge
      send_pixel(make_pixel(16'hFFFF, -1, 0, 1'b0));
      send_pixel(make_pixel(16'h0000, 0, 0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 1, 0, 1'b0));
      send_pixel(make_pixel(16'h1234, 2, 0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 3, 0, 1'b0));
      send_pixel(make_pixel(16'h8000, 4, 0, 1'b0));
      send_pixel(make_pixel(16'h0001, 5, 0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 6, 0, 1'b1));
      // flush at row end
      send_pixel(make_pixel(16'hFFFF, 4, 1, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 5, 1, 1'b1));
      // drop an open run on a skipped row
      send_pixel(make_pixel(16'hFFFF, 0, 2, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 1, -1, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 1, 2, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 0, 3, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 0, 4, 1'b1));
      // columns that step backwards
      send_pixel(make_pixel(16'hFFFF, 5, 0, 1'b0));
      send_pixel(make_pixel(16'h1234, 0, 0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, 3, 0, 1'b0));
      send_pixel(make_pixel(16'hFFFF, -8, 0, 1'b1));
      send_pixel(make_pixel(16'h0000, -8192, -8192, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 8191, 8191, 1'b1));
      release_pixels();
      drain_runs();
   endtask

   task automatic test_large_sizes;
      set_config(16'hFFFF, 0, 0, 8191, 4096, 4096, 8191, 1'b0);
      send_pixel(make_pixel(16'h0000, 4094, 4095, 1'b0));
      send_pixel(make_pixel(16'h7FFF, 4095, 4095, 1'b1));
      send_pixel(make_pixel(16'h0000, 4096, 0, 1'b1));
      send_pixel(make_pixel(16'hFFFF, 4095, 0, 1'b1));
      release_pixels();
      drain_runs();
      set_config(16'h0000, 0, 0, 0, 8, 8, 8, 1'b0);
      send_pixel(make_pixel(16'hFFFF, 0, 0, 1'b1));
      release_pixels();
      drain_runs();
      set_config(16'h0000, -8192, 8191, 4096, 4096, 4096, 4096, 1'b0);
      send_pixel(make_pixel(16'hFFFF, 8191, 0, 1'b1));
      release_pixels();
      drain_runs();
      set_config(16'h0000, 8191, -8192, 4096, 4096, 4096, 4096, 1'b0);
      send_pixel(make_pixel(16'hFFFF, 0, 8191, 1'b1));
      release_pixels();
      drain_runs();
   endtask

   task automatic test_random_windows;
      int key, dx, dy, sent, cols, rows, sx, sy;
      int dims[4];
      for (int phase = 0; phase < 8; phase++) begin
         tx_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
         rx_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
         key = $urandom_range(0, 65535);
         dx = int'($urandom_range(0, 12)) - 6;
         dy = int'($urandom_range(0, 12)) - 6;
         for (int k = 0; k < 4; k++) dims[k] = $urandom_range(1, 40);
         case (phase)
            2: dims = '{4096, 4096, 4096, 4096};
            3: begin
               for (int k = 0; k < 4; k++) dims[k] = $urandom_range(4097, 8191);
            end
            4: begin
               dims = '{4096, 4096, 4096, 4096};
               dx = -4000;
               dy = 4000;
            end
            5: dims[$urandom_range(0, 3)] = 0;
            6: key = 16'h0000;
            7: key = 16'hFFFF;
            default: ;
         endcase
         set_config(key, dx, dy, dims[0], dims[1], dims[2], dims[3], phase % 2 == 1);
         sent = 0;
         while (sent < 130) begin
            cols = $urandom_range(1, 24);
            rows = $urandom_range(1, 6);
            sx = pick_start(dims[0]);
            sy = pick_start(dims[1]);
            send_window(sx, sy, cols, rows, key);
            sent += cols * rows;
         end
         release_pixels();
         drain_runs();
      end
   endtask

   task automatic test_pressure;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(16'h0000, 0, 0, 64, 64, 64, 64, 1'b0);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 160; i++)
         send_pixel(make_pixel((i % 2 == 1) ? 0 : 16'h5A00 + i, i % 16, i / 16,
                               i % 16 == 15));
      release_pixels();
      drain_runs();
   endtask

   task automatic test_noise;
      item_type it;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      set_config(16'h00FF, 2, 1, 16, 8, 20, 10, 1'b0);
      for (int i = 0; i < 200; i++) begin
         if (i % 2 == 1) begin
            it.pixel = 16'($urandom_range(0, 65535));
            it.src_col = 14'($urandom_range(0, 16383));
            it.src_row = 14'($urandom_range(0, 16383));
            it.row_end = 1'($urandom_range(0, 1));
         end else begin
            it = make_pixel(($urandom_range(0, 3) == 0) ? 16'h00FF : $urandom_range(0, 65535),
                            int'($urandom_range(0, 23)) - 3, int'($urandom_range(0, 9)) - 1,
                            $urandom_range(0, 5) == 0);
         end
         send_pixel(it);
      end
      release_pixels();
      drain_runs();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      req_chan.src_col = '0;
      req_chan.src_row = '0;
      req_chan.row_end = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_edges();
      test_large_sizes();
      test_random_windows();
      test_pressure();
      test_noise();
      if (error_count == 0)
         $display("** color_key_opaque_run_extractor_unit: PASSED **");
      else
         $display("** color_key_opaque_run_extractor_unit: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** color_key_opaque_run_extractor_unit: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ckre_pkg.sv
rtl/ckre_if.sv
rtl/ckre_csr.sv
rtl/ckre_classify.sv
rtl/color_key_opaque_run_extractor_unit.sv
rtl/ckre_checker.sv
tb/tb.sv
